// ===== src/sfcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcc_pkg: shared types, constants and the CRC-8 update for the frame checker
// Reflected CRC-8 (poly 0x8C), item structs, register map.
// ----------------------------------------------------------------------------
package sfcc_pkg;

    localparam logic [7:0]  CRC_POLY          = 8'h8C;
    localparam logic [15:0] FAIL_TEMP         = 16'd1360;   // 85.0 C in 1/16 C
    localparam logic [4:0]  FRAME_BYTES_RESET = 5'd9;
    localparam logic [4:0]  FRAME_BYTES_MIN   = 5'd2;
    localparam logic [4:0]  FRAME_BYTES_MAX   = 5'd16;

    localparam int          CFG_ADDR_W        = 3;
    localparam int          CFG_DATA_W        = 32;
    localparam logic [CFG_ADDR_W-1:0] ADDR_FRAME_BYTES = 3'd0;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic               crc_ok;
        logic [7:0]         crc_value;
        logic signed [15:0] temp_sixteenths;
    } out_item_t;

    // engine status back to the pipeline control
    typedef struct packed {
        logic      is_last;
        out_item_t result;
    } frame_status_t;

    // one byte through the reflected CRC, LSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data);
        logic [7:0] c;
        logic       mix;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            mix = c[0] ^ data[i];
            c   = {1'b0, c[7:1]};
            if (mix)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/sensor_frame_crc_checker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_crc_checker_top: one-wire sensor frame CRC checker
//
// Bytes of a frame enter on the byte channel (byte_valid/byte_ready/
// byte_item), one item per handshake. All bytes but the last feed a
// reflected CRC-8; bytes 0 and 1 form the little-endian temperature.
// The last byte of a frame is compared against the CRC and gives one item
// on the result channel (result_valid/result_ready/result_item); other
// bytes give none. restart in a byte item starts a new frame with it.
// frame_bytes is set through the APB-style port at address 0.
// A byte is registered in the input register on accept and evaluated there;
// a last byte's result then goes into the result register. One byte per
// cycle is taken while the staged byte gives no result or the result
// register is free, set by the combinational CRC update between the two.
// Reset clears the frame state and both pipeline registers, frame_bytes
// returns to 9. When the receiver stalls, the result register holds and the
// input register keeps taking bytes that give no result; a second result
// waits in the input register and byte_ready drops until the first leaves.
// ----------------------------------------------------------------------------
module sensor_frame_crc_checker_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            byte_valid,
    output logic                            byte_ready,
    input  sfcc_pkg::in_item_t              byte_item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output sfcc_pkg::out_item_t             result_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sfcc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfcc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfcc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import sfcc_pkg::*;

    logic          stage_valid_reg;
    logic          stage_valid_next;
    in_item_t      stage_item_reg;
    in_item_t      stage_item_next;
    logic          res_valid_reg;
    logic          res_valid_next;
    out_item_t     res_item_reg;
    out_item_t     res_item_next;

    logic [3:0]    last_pos;
    frame_status_t status;
    logic          res_free;
    logic          advance;
    logic          byte_take;

    sfcc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .last_pos (last_pos)
    );

    sfcc_frame_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (stage_item_reg),
        .step     (advance),
        .last_pos (last_pos),
        .status   (status)
    );

    // the staged item moves on unless it has a result and the output is full
    assign res_free   = !res_valid_reg || result_ready;
    assign advance    = stage_valid_reg && (!status.is_last || res_free);
    assign byte_ready = !stage_valid_reg || advance;
    assign byte_take  = byte_valid && byte_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_item_next  = stage_item_reg;
        if (byte_take)
        begin
            stage_valid_next = 1'b1;
            stage_item_next  = byte_item;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_item_next  = res_item_reg;
        if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (advance && status.is_last)
        begin
            res_valid_next = 1'b1;
            res_item_next  = status.result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_item_reg <= stage_item_next;
        res_item_reg   <= res_item_next;
    end

    assign result_valid = res_valid_reg;
    assign result_item  = res_item_reg;

endmodule

// ===== src/sfcc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcc_cfg_regs: configuration register file
// Holds frame_bytes behind the APB-style port and derives the last position.
// ----------------------------------------------------------------------------
module sfcc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sfcc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfcc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfcc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [3:0]                      last_pos
);
    import sfcc_pkg::*;

    logic [4:0] frame_bytes_reg;
    logic [4:0] frame_bytes_next;
    logic [4:0] len_clamped;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_FRAME_BYTES);

    always_comb
    begin
        frame_bytes_next = frame_bytes_reg;
        if (wr_en)
        begin
            frame_bytes_next = pwdata[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bytes_reg <= FRAME_BYTES_RESET;
        end
        else
        begin
            frame_bytes_reg <= frame_bytes_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_FRAME_BYTES)
        begin
            prdata[4:0] = frame_bytes_reg;
        end
    end

    // out-of-range lengths act as the nearest bound
    always_comb
    begin
        if (frame_bytes_reg < FRAME_BYTES_MIN)
        begin
            len_clamped = FRAME_BYTES_MIN;
        end
        else if (frame_bytes_reg > FRAME_BYTES_MAX)
        begin
            len_clamped = FRAME_BYTES_MAX;
        end
        else
        begin
            len_clamped = frame_bytes_reg;
        end
    end

    assign last_pos = 4'(len_clamped - 5'd1);

endmodule

// ===== src/sfcc_frame_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcc_frame_engine: per-frame CRC and temperature state
// Evaluates one byte against the running frame state; commits on step.
// ----------------------------------------------------------------------------
module sfcc_frame_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sfcc_pkg::in_item_t      item,
    input  logic                    step,
    input  logic [3:0]              last_pos,
    output sfcc_pkg::frame_status_t status
);
    import sfcc_pkg::*;

    logic [7:0]  crc_acc_reg;
    logic [7:0]  crc_acc_next;
    logic [3:0]  byte_index_reg;
    logic [3:0]  byte_index_next;
    logic [15:0] temp_word_reg;
    logic [15:0] temp_word_next;

    logic [7:0]  crc_cur;
    logic [3:0]  idx_cur;
    logic [15:0] temp_cur;
    logic        ok;

    // restart clears the frame before this byte is looked at
    assign crc_cur  = item.restart ? 8'd0  : crc_acc_reg;
    assign idx_cur  = item.restart ? 4'd0  : byte_index_reg;
    assign temp_cur = item.restart ? 16'd0 : temp_word_reg;

    // a shrunk length makes any later position the CRC byte
    assign status.is_last = (idx_cur >= last_pos);
    assign ok             = (item.rx_byte == crc_cur);

    assign status.result.crc_ok          = ok;
    assign status.result.crc_value       = crc_cur;
    assign status.result.temp_sixteenths = ok ? signed'(temp_cur) : signed'(FAIL_TEMP);

    always_comb
    begin
        crc_acc_next    = crc_acc_reg;
        byte_index_next = byte_index_reg;
        temp_word_next  = temp_word_reg;
        if (step)
        begin
            if (status.is_last)
            begin
                crc_acc_next    = 8'd0;
                byte_index_next = 4'd0;
                temp_word_next  = 16'd0;
            end
            else
            begin
                crc_acc_next    = crc8_update(crc_cur, item.rx_byte);
                byte_index_next = idx_cur + 4'd1;
                temp_word_next  = temp_cur;
                if (idx_cur == 4'd0)
                begin
                    temp_word_next[7:0] = item.rx_byte;
                end
                else if (idx_cur == 4'd1)
                begin
                    temp_word_next[15:8] = item.rx_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_acc_reg    <= 8'd0;
            byte_index_reg <= 4'd0;
            temp_word_reg  <= 16'd0;
        end
        else
        begin
            crc_acc_reg    <= crc_acc_next;
            byte_index_reg <= byte_index_next;
            temp_word_reg  <= temp_word_next;
        end
    end

endmodule
